// File: sv/one_pole_lowpass_smoother_assert.svh
// ----------------------------------------------------------------------------
// one_pole_lowpass_smoother_assert.svh
// Assertion macros shared by the smoother RTL.
// ----------------------------------------------------------------------------
`ifndef ONE_POLE_LOWPASS_SMOOTHER_ASSERT_SVH
`define ONE_POLE_LOWPASS_SMOOTHER_ASSERT_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define OPLS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define OPLS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/opls_pkg.sv
// ----------------------------------------------------------------------------
// opls_pkg
// Types, codes and Q1.31 helper functions for the one-pole smoother.
// ----------------------------------------------------------------------------
package opls_pkg;

    typedef logic signed [31:0] t_q31;
    typedef logic signed [32:0] t_q31_wide;

    // action codes
    localparam logic ACT_STEP = 1'b0;
    localparam logic ACT_SYNC = 1'b1;

    // register index, taken from paddr[2]
    localparam logic REG_COEFF = 1'b0;
    localparam logic REG_MODE  = 1'b1;

    localparam t_q31 COEFF_RESET    = 32'sh7F00_0000;
    localparam t_q31 Q31_MAX        = 32'sh7FFF_FFFF;
    localparam t_q31 Q31_MIN        = 32'sh8000_0000;
    localparam t_q31 SNAP_THRESHOLD = 32'sh0000_4000;

    // clamp a 33-bit signed value into Q1.31
    function automatic t_q31 sat33(input t_q31_wide v);
        t_q31 res;
        if (v[32] != v[31]) begin
            res = v[32] ? Q31_MIN : Q31_MAX;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

    // count of redundant sign bits, 0..31
    function automatic logic [4:0] sign_bits(input t_q31 x);
        logic [30:0] u;
        logic [4:0]  n;
        u = x[31] ? ~x[30:0] : x[30:0];
        n = 5'd31;
        for (int i = 0; i < 31; i++) begin
            if (u[i]) begin
                n = 5'(30 - i);
            end
        end
        return n;
    endfunction

endpackage

// File: sv/one_pole_lowpass_smoother.sv
// ----------------------------------------------------------------------------
// one_pole_lowpass_smoother
// Q1.31 one-pole lowpass smoother with sync/snap query and APB registers.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+---------------------------
//  input   | in        | i_in_valid / o_in_stall   | i_action, i_target
//  output  | out       | o_out_valid / i_out_stall | o_value, o_settled
//  config  | in        | psel, penable, pwrite     | paddr, pwdata, prdata
//
//  Each word sits in the input register while the filter math runs on it,
//  and the result register (the filter state itself) loads as the word
//  advances, which waits while a stalled result is held. One word per
//  cycle sustained while i_out_stall is low. The sign count, the two
//  shifters, 32x32 multiply and saturating add form the combinational path.
//  Reset (synchronous, i_rst_n low) empties both stages, zeroes the state
//  and loads coefficient 0x7F000000, plain mode.
//  A stalled result holds; the input stage still takes one word and then
//  raises o_in_stall until the result moves.
// ----------------------------------------------------------------------------
module one_pole_lowpass_smoother (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input words
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_action,
    input  logic signed [31:0]   i_target,
    // result words
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic signed [31:0]   o_value,
    output logic                 o_settled,
    // register port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    opls_pkg::t_q31 r_coeff;
    logic           r_norm;

    logic           r_in_valid;
    logic           r_action;
    opls_pkg::t_q31 r_target;

    logic           r_out_valid;
    opls_pkg::t_q31 r_state;
    logic           r_settled;

    opls_pkg::t_q31 n_state;
    logic           n_settled;

    logic           w_advance;
    logic           w_take;

    // ------------------------------------------------------------------
    // Configuration: decode on paddr[2] only, pready tied high
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign prdata = (paddr[2] == opls_pkg::REG_MODE) ? {31'b0, r_norm} : r_coeff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coeff <= opls_pkg::COEFF_RESET;
            r_norm  <= 1'b0;
        end else if (psel && penable && pwrite && pready) begin
            case (paddr[2])
                opls_pkg::REG_COEFF: r_coeff <= pwdata;
                opls_pkg::REG_MODE:  r_norm  <= pwdata[0];
                default:             r_norm  <= r_norm;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Flow control: advance the input stage when the result slot frees
    // ------------------------------------------------------------------
    assign w_advance  = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !w_advance;
    assign w_take     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_take) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    // hold the captured word until it advances
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_action <= i_action;
            r_target <= i_target;
        end
    end

    // ------------------------------------------------------------------
    // Filter step: state = target + coeff * (state - target)
    // ------------------------------------------------------------------
    opls_pkg::t_q31        w_diff;
    logic [4:0]            w_shift;
    opls_pkg::t_q31        w_mul_in;
    logic signed [63:0]    w_prod;
    opls_pkg::t_q31        w_qprod;
    opls_pkg::t_q31        w_scaled;
    opls_pkg::t_q31        w_step;

    assign w_diff  = opls_pkg::sat33({r_state[31], r_state} - {r_target[31], r_target});
    assign w_shift = opls_pkg::sign_bits(w_diff);

    // normalize: shifting by the redundant sign count cannot overflow
    assign w_mul_in = r_norm ? (w_diff <<< w_shift) : w_diff;
    assign w_prod   = r_coeff * w_mul_in;
    // floor of product / 2^31; only -1 * -1 clips
    assign w_qprod  = opls_pkg::sat33(w_prod[63:31]);
    assign w_scaled = r_norm ? (w_qprod >>> w_shift) : w_qprod;
    assign w_step   = opls_pkg::sat33({r_target[31], r_target} + {w_scaled[31], w_scaled});

    // ------------------------------------------------------------------
    // Sync query: report equality, snap when close
    // ------------------------------------------------------------------
    opls_pkg::t_q31 w_gap;
    opls_pkg::t_q31 w_gap_abs;
    logic           w_equal;
    logic           w_snap;

    assign w_equal   = (r_state == r_target);
    assign w_gap     = opls_pkg::sat33({r_target[31], r_target} - {r_state[31], r_state});
    assign w_gap_abs = !w_gap[31]                   ? w_gap :
                       (w_gap == opls_pkg::Q31_MIN) ? opls_pkg::Q31_MAX : -w_gap;
    assign w_snap    = (w_gap_abs < opls_pkg::SNAP_THRESHOLD);

    always_comb begin
        n_state   = r_state;
        n_settled = 1'b0;
        case (r_action)
            opls_pkg::ACT_STEP: begin
                n_state = w_step;
            end
            opls_pkg::ACT_SYNC: begin
                if (w_equal) begin
                    n_settled = 1'b1;
                end else if (w_snap) begin
                    n_state = r_target;
                end
            end
            default: begin
                n_state = r_state;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Result register: the filter state doubles as the output value
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_state     <= '0;
            r_settled   <= 1'b0;
        end else begin
            if (w_advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
                r_settled   <= n_settled;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_value     = r_state;
    assign o_settled   = r_settled;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    logic w_adv_step;
    logic w_adv_equal;

    assign w_adv_step  = w_advance && (r_action == opls_pkg::ACT_STEP);
    assign w_adv_equal = w_advance && (r_action == opls_pkg::ACT_SYNC) && w_equal;

`include "one_pole_lowpass_smoother_assert.svh"

    `OPLS_ASSERT_NEXT(a_advance_fills_out, w_advance, r_out_valid, "advanced word lost")
    `OPLS_ASSERT_NEXT(a_step_not_settled, w_adv_step, !o_settled, "settled set on filter step")
    `OPLS_ASSERT_NEXT(a_settled_keeps_state, w_adv_equal, o_settled && (o_value == $past(r_state)), "settled sync changed state")

endmodule
